// ===== rtl/ddar_pkg.sv =====
// Package for the DDA line rasterizer: widths, command and status structs.
// No dependencies; used by every module under rtl/.
package ddar_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int ACC_W      = COORD_BITS + FRAC_BITS + 2;
    localparam int STEP_W     = FRAC_BITS + 2;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int NUM_W      = COORD_BITS + FRAC_BITS + 2;
    localparam int DEN_W      = COORD_BITS + 1;
    localparam int PIX_W      = ACC_W - FRAC_BITS;
    localparam int CNT_W      = $clog2(QUOT_W);
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic action_start = 1'b0;
    localparam logic action_step  = 1'b1;

    typedef struct packed {
        logic start;
        logic setup;
        logic div_run;
        logic fin;
        logic step;
        logic move;
        logic pend_last;
    } cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic left_one;
    } stat_t;

endpackage

// ===== rtl/dda_line_rasterizer_top.sv =====
// Top level of the DDA line rasterizer: controller plus datapath.
// Depends on ddar_pkg, ddar_ctrl, ddar_datapath, ddar_div.
//
// channel  | dir | signals                       | payload
// s_axis   | in  | tvalid tready tdata tuser     | endpoints, action
// m_axis   | out | tvalid tready tdata tlast     | pixel x/y, last pixel
//
// Step pixels pass pending then output registers; one per cycle unless the output stalls.
// A start request with distinct endpoints blocks input through the setup, divide and finish
// states of the bit-serial increment divider; its first pixel leaves meanwhile.
// Reset clears the line, pending pixel and output valid; no line is active after reset.
// A stalled output holds its pixel; one more request is accepted behind it, then input stalls.
module dda_line_rasterizer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  logic [ddar_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_y
    output logic [ddar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    ddar_pkg::cmd_t  cmd;
    ddar_pkg::stat_t stat;

    ddar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddar_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule

// ===== rtl/ddar_div.sv =====
// Restoring divider, one quotient bit per cycle while run is asserted, for the per-step increment.
// Depends on ddar_pkg.
module ddar_div (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         run,
    input  logic [ddar_pkg::NUM_W-1:0]   numer,
    input  logic [ddar_pkg::DEN_W-1:0]   denom,
    output logic [ddar_pkg::QUOT_W-1:0]  quot
);

    logic [ddar_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [ddar_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [ddar_pkg::QUOT_W-1:0] sh_reg, sh_next;
    logic [ddar_pkg::DEN_W:0]    trial;
    logic [ddar_pkg::DEN_W:0]    diff;

    assign trial = {rem_reg, sh_reg[ddar_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        sh_next  = sh_reg;
        if (load)
        begin
            rem_next = numer[ddar_pkg::NUM_W-1:ddar_pkg::QUOT_W];
            sh_next  = numer[ddar_pkg::QUOT_W-1:0];
            den_next = denom;
        end
        else if (run)
        begin
            if (trial >= {1'b0, den_reg})
                rem_next = diff[ddar_pkg::DEN_W-1:0];
            else
                rem_next = trial[ddar_pkg::DEN_W-1:0];
            sh_next = {sh_reg[ddar_pkg::QUOT_W-2:0], (trial >= {1'b0, den_reg})};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign quot = sh_reg;

endmodule

// ===== rtl/ddar_datapath.sv =====
// Datapath: endpoint differences, increments, accumulators, pixel rounding, output register.
// Depends on ddar_pkg and ddar_div.
module ddar_datapath (
    input  logic                                clk,
    input  ddar_pkg::cmd_t                      cmd,
    output ddar_pkg::stat_t                     stat,
    input  logic [ddar_pkg::IN_DATA_W-1:0]      in_data,
    output logic [ddar_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                                out_last
);

    localparam int C = ddar_pkg::COORD_BITS;
    localparam int F = ddar_pkg::FRAC_BITS;

    logic [C-1:0] x0, y0, x1, y1;
    logic signed [ddar_pkg::DIFF_W-1:0] dx_next, dy_next;
    logic signed [ddar_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic [ddar_pkg::DIFF_W-1:0] absx, absy;
    logic [C-1:0] adx, ady, steps;
    logic [ddar_pkg::NUM_W-1:0] numx, numy;
    logic [ddar_pkg::DEN_W-1:0] den;
    logic [ddar_pkg::QUOT_W-1:0] qx, qy;
    logic [ddar_pkg::STEP_W-1:0] qx_ext, qy_ext;

    logic x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic [C-1:0] left_reg, left_next;
    logic [ddar_pkg::ACC_W-1:0] x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic [ddar_pkg::STEP_W-1:0] x_step_reg, x_step_next, y_step_reg, y_step_next;
    logic [C-1:0] px_reg, px_next, py_reg, py_next;
    logic last_reg, last_next;

    function automatic logic [C-1:0] to_pixel(input logic [ddar_pkg::ACC_W-1:0] acc);
        logic [ddar_pkg::ACC_W-1:0] bias;
        logic [ddar_pkg::ACC_W-1:0] sum;
        logic signed [ddar_pkg::PIX_W-1:0] p;
        logic signed [ddar_pkg::PIX_W-1:0] pmax;
        logic signed [ddar_pkg::PIX_W-1:0] pmin;
        bias = ddar_pkg::ACC_W'(1) << (F - 1);
        if (acc[ddar_pkg::ACC_W-1])
            bias = bias - ddar_pkg::ACC_W'(1);
        sum  = acc + bias;
        p    = sum[ddar_pkg::ACC_W-1:F];
        pmax = ddar_pkg::PIX_W'((1 << (C - 1)) - 1);
        pmin = -pmax - ddar_pkg::PIX_W'(1);
        if (p > pmax)
            return pmax[C-1:0];
        else if (p < pmin)
            return pmin[C-1:0];
        else
            return p[C-1:0];
    endfunction

    assign x0 = in_data[C-1:0];
    assign y0 = in_data[2*C-1:C];
    assign x1 = in_data[3*C-1:2*C];
    assign y1 = in_data[4*C-1:3*C];

    assign dx_next = signed'({x1[C-1], x1}) - signed'({x0[C-1], x0});
    assign dy_next = signed'({y1[C-1], y1}) - signed'({y0[C-1], y0});

    assign absx  = dx_reg[C] ? (~dx_reg + ddar_pkg::DIFF_W'(1)) : dx_reg;
    assign absy  = dy_reg[C] ? (~dy_reg + ddar_pkg::DIFF_W'(1)) : dy_reg;
    assign adx   = absx[C-1:0];
    assign ady   = absy[C-1:0];
    assign steps = (adx > ady) ? adx : ady;

    assign numx = ddar_pkg::NUM_W'({adx, ddar_pkg::QUOT_W'(0)}) + ddar_pkg::NUM_W'(steps);
    assign numy = ddar_pkg::NUM_W'({ady, ddar_pkg::QUOT_W'(0)}) + ddar_pkg::NUM_W'(steps);
    assign den  = {steps, 1'b0};

    ddar_div u_div_x (
        .clk   (clk),
        .load  (cmd.setup),
        .run   (cmd.div_run),
        .numer (numx),
        .denom (den),
        .quot  (qx)
    );

    ddar_div u_div_y (
        .clk   (clk),
        .load  (cmd.setup),
        .run   (cmd.div_run),
        .numer (numy),
        .denom (den),
        .quot  (qy)
    );

    assign qx_ext = {1'b0, qx};
    assign qy_ext = {1'b0, qy};

    always_comb
    begin
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        left_next   = left_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_step_next = x_step_reg;
        y_step_next = y_step_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        last_next   = last_reg;
        if (cmd.start)
        begin
            x_acc_next = {{2{x0[C-1]}}, x0, F'(0)};
            y_acc_next = {{2{y0[C-1]}}, y0, F'(0)};
        end
        if (cmd.setup)
        begin
            x_neg_next = dx_reg[C];
            y_neg_next = dy_reg[C];
            left_next  = steps;
        end
        if (cmd.fin)
        begin
            x_step_next = x_neg_reg ? (~qx_ext + ddar_pkg::STEP_W'(1)) : qx_ext;
            y_step_next = y_neg_reg ? (~qy_ext + ddar_pkg::STEP_W'(1)) : qy_ext;
        end
        if (cmd.step)
        begin
            x_acc_next = x_acc_reg
                + {{(ddar_pkg::ACC_W-ddar_pkg::STEP_W){x_step_reg[ddar_pkg::STEP_W-1]}},
                   x_step_reg};
            y_acc_next = y_acc_reg
                + {{(ddar_pkg::ACC_W-ddar_pkg::STEP_W){y_step_reg[ddar_pkg::STEP_W-1]}},
                   y_step_reg};
            left_next  = left_reg - C'(1);
        end
        if (cmd.move)
        begin
            px_next   = to_pixel(x_acc_reg);
            py_next   = to_pixel(y_acc_reg);
            last_next = cmd.pend_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        x_neg_reg  <= x_neg_next;
        y_neg_reg  <= y_neg_next;
        left_reg   <= left_next;
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        x_step_reg <= x_step_next;
        y_step_reg <= y_step_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
    end

    assign stat.steps_zero = (x0 == x1) && (y0 == y1);
    assign stat.left_one   = (left_reg == C'(1));

    assign out_data = ddar_pkg::OUT_DATA_W'({py_reg, px_reg});
    assign out_last = last_reg;

endmodule

// ===== rtl/ddar_ctrl.sv =====
// Controller: line sequencing, divider count, pending pixel and output valid.
// Depends on ddar_pkg.
module ddar_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_action,
    output logic             out_valid,
    input  logic             out_ready,
    input  ddar_pkg::stat_t  stat,
    output ddar_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [ddar_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic active_reg, active_next;
    logic pend_reg, pend_next;
    logic pend_last_reg, pend_last_next;
    logic out_valid_reg, out_valid_next;
    logic accept, start, step, move;

    assign move     = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE) && (!pend_reg || move);
    assign accept   = in_valid && in_ready;
    assign start    = accept && (in_action == ddar_pkg::action_start);
    assign step     = accept && (in_action == ddar_pkg::action_step) && active_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;

        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        if (move)
            pend_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = stat.steps_zero;
                    active_next    = !stat.steps_zero;
                    if (!stat.steps_zero)
                        state_next = ST_SETUP;
                end
                else if (step)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = stat.left_one;
                    active_next    = !stat.left_one;
                end
            end
            ST_SETUP:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + ddar_pkg::CNT_W'(1);
                if (cnt_reg == ddar_pkg::CNT_W'(ddar_pkg::QUOT_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cmd.start     = start;
    assign cmd.setup     = (state_reg == ST_SETUP);
    assign cmd.div_run   = (state_reg == ST_DIV);
    assign cmd.fin       = (state_reg == ST_FIN);
    assign cmd.step      = step;
    assign cmd.move      = move;
    assign cmd.pend_last = pend_last_reg;

endmodule

// ===== rtl/ddar_checker.sv =====
// Port-level checker for the DDA line rasterizer, bound to the top level.
// Depends on ddar_pkg and dda_line_rasterizer_top.
module ddar_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [ddar_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [ddar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tlast
);

    localparam int C = ddar_pkg::COORD_BITS;

    logic start_acc;
    logic endpoints_differ;

    assign start_acc = s_axis_tvalid && s_axis_tready
                       && (s_axis_tuser == ddar_pkg::action_start);
    assign endpoints_differ = (s_axis_tdata[C-1:0] != s_axis_tdata[3*C-1:2*C])
                              || (s_axis_tdata[2*C-1:C] != s_axis_tdata[4*C-1:3*C]);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc && endpoints_differ |=> !s_axis_tready)
        else $error("input accepted during increment setup");

    a_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc && (!m_axis_tvalid || m_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("first pixel of a line not delivered");

endmodule

bind dda_line_rasterizer_top ddar_checker u_ddar_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
